// ===== rtl/hte_pkg.sv =====
// Shared types, constants and helpers for the homogeneous transform engine.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hte_pkg;

	// Q16.16 words, exact dot-product accumulator
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int ACC_BITS  = 2 * WORD_BITS - FRAC_BITS + 2;

	localparam logic [WORD_BITS-1:0] ONE_VALUE = WORD_BITS'(64'd1 << FRAC_BITS);
	localparam logic [WORD_BITS-1:0] WORD_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] WORD_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [ACC_BITS-1:0]  acc_t;

	// Command codes on the input word
	typedef enum logic [2:0] {
		CMD_WRITE   = 3'd0,
		CMD_COMPOSE = 3'd1,
		CMD_COPY    = 3'd2,
		CMD_IDENT   = 3'd3,
		CMD_XFORM   = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WAIT_OUT,
		ST_MAC,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic       wr_elem;
		logic       copy_stg;
		logic       set_ident;
		logic       load_vtx;
		logic       issue;
		logic       compose;
		logic       first;
		logic       last;
		logic [1:0] col;
		logic [1:0] step;
		logic       commit;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_full;
		logic res_done;
	} dp_sts_t;

	typedef struct packed {
		logic                 clip;
		logic [WORD_BITS-1:0] val;
	} sat_t;

	// Clamp an exact sum to one word
	function automatic sat_t sat_word(acc_t a);
		sat_t                       r;
		logic [ACC_BITS-WORD_BITS:0] hi;
		hi = a[ACC_BITS-1:WORD_BITS-1];
		if ((&hi) || (~|hi)) begin
			r.clip = 1'b0;
			r.val  = a[WORD_BITS-1:0];
		end else if (a[ACC_BITS-1]) begin
			r.clip = 1'b1;
			r.val  = WORD_MIN;
		end else begin
			r.clip = 1'b1;
			r.val  = WORD_MAX;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/homogeneous_transform_engine_unit.sv =====
// Transform vertex: waits until the output register is free, then four lane
// multipliers step over four matrix columns, followed by the product and
// accumulate stages; the next vertex is accepted once the result word is written.
// Compose: busy for 16 steps, drain and one commit. Write, copy, identity stay in idle.
// Reset: both matrices return to identity, output register empty.
// Depends on hte_pkg, hte_ctrl and hte_datapath.
`timescale 1ns / 1ps
`default_nettype none

module homogeneous_transform_engine_unit import hte_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] command,
	input  wire logic [3:0] element_index,
	input  wire word_t      element_value,
	input  wire word_t      in_x,
	input  wire word_t      in_y,
	input  wire word_t      in_z,
	input  wire word_t      in_w,
	output logic            out_valid,
	input  wire logic       out_ready,
	output word_t           out_x,
	output word_t           out_y,
	output word_t           out_z,
	output word_t           out_w,
	output logic            saturated
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	hte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.sts      (sts),
		.cmd      (cmd)
	);

	hte_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.element_index (element_index),
		.element_value (element_value),
		.in_x          (in_x),
		.in_y          (in_y),
		.in_z          (in_z),
		.in_w          (in_w),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_z         (out_z),
		.out_w         (out_w),
		.saturated     (saturated)
	);

endmodule

`default_nettype wire

// ===== rtl/hte_ctrl.sv =====
// Controller of the transform engine: accepts words, sequences the four
// multiply-accumulate steps per column and commits a composed matrix.
// Depends on hte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hte_ctrl import hte_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] command,
	input  wire dp_sts_t    sts,
	output dp_cmd_t         cmd
);

	state_t     state_q, state_d;
	logic [3:0] cnt_q;
	logic       cmp_q;
	logic       accept;
	logic       last_issue;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	// compose runs four columns of four steps, a vertex one column
	assign last_issue = cmp_q ? (cnt_q == 4'hF) : (cnt_q == 4'h3);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && command == CMD_COMPOSE)
					state_d = ST_MAC;
				else if (accept && command == CMD_XFORM)
					state_d = ST_WAIT_OUT;
			end
			ST_WAIT_OUT: begin
				if (!sts.out_full)
					state_d = ST_MAC;
			end
			ST_MAC: begin
				if (last_issue)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (sts.res_done)
					state_d = cmp_q ? ST_COMMIT : ST_IDLE;
			end
			ST_COMMIT: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr_elem   = accept && (command == CMD_WRITE);
				cmd.copy_stg  = accept && (command == CMD_COPY);
				cmd.set_ident = accept && (command == CMD_IDENT);
				cmd.load_vtx  = accept && (command == CMD_XFORM);
			end
			ST_MAC: begin
				cmd.issue   = 1'b1;
				cmd.compose = cmp_q;
				cmd.step    = cnt_q[1:0];
				cmd.col     = cnt_q[3:2];
				cmd.first   = (cnt_q[1:0] == 2'd0);
				cmd.last    = (cnt_q[1:0] == 2'd3);
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	// state, step counter, mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			cmp_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MAC)
				cnt_q <= cnt_q + 4'd1;
			else
				cnt_q <= '0;
			if (accept)
				cmp_q <= (command == CMD_COMPOSE);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hte_datapath.sv =====
// Datapath of the transform engine: matrix registers, four multiply lanes,
// exact accumulators, saturation and the output word register.
// Depends on hte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hte_datapath import hte_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_cmd_t    cmd,
	output dp_sts_t         sts,
	input  wire logic [3:0] element_index,
	input  wire word_t      element_value,
	input  wire word_t      in_x,
	input  wire word_t      in_y,
	input  wire word_t      in_z,
	input  wire word_t      in_w,
	output logic            out_valid,
	input  wire logic       out_ready,
	output word_t           out_x,
	output word_t           out_y,
	output word_t           out_z,
	output word_t           out_w,
	output logic            saturated
);

	logic [WORD_BITS-1:0] cur_q [16];
	logic [WORD_BITS-1:0] stg_q [16];
	logic [WORD_BITS-1:0] nxt_q [16];
	word_t                vtx_q [4];

	word_t      op_a [4];
	word_t      op_b;
	prod_t      prod_s1 [4];
	logic       vld_s1, first_s1, last_s1, cmp_s1;
	logic [1:0] col_s1;
	acc_t       acc_s2 [4];
	logic       done_s2, cmp_s2;
	logic [1:0] col_s2;
	sat_t       sat_r [4];
	logic       out_valid_q;
	word_t      out_q [4];
	logic       sat_q;

	// matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				cur_q[i] <= (i % 5 == 0) ? ONE_VALUE : '0;
				stg_q[i] <= (i % 5 == 0) ? ONE_VALUE : '0;
			end
		end else begin
			if (cmd.wr_elem)
				stg_q[element_index] <= element_value;
			if (cmd.copy_stg)
				cur_q <= stg_q;
			else if (cmd.set_ident) begin
				for (int i = 0; i < 16; i++)
					cur_q[i] <= (i % 5 == 0) ? ONE_VALUE : '0;
			end else if (cmd.commit)
				cur_q <= nxt_q;
		end
	end

	// vertex latch
	always_ff @(posedge clk) begin
		if (cmd.load_vtx) begin
			vtx_q[0] <= in_x;
			vtx_q[1] <= in_y;
			vtx_q[2] <= in_z;
			vtx_q[3] <= in_w;
		end
	end

	// operand select: lane r takes current[step][r]; shared operand is the
	// vertex element or the staging element of the column being built
	always_comb begin
		for (int l = 0; l < 4; l++)
			op_a[l] = cur_q[{cmd.step, 2'(l)}];
		op_b = cmd.compose ? stg_q[{cmd.col, cmd.step}] : vtx_q[cmd.step];
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			for (int l = 0; l < 4; l++)
				prod_s1[l] <= PROD_BITS'(op_a[l]) * PROD_BITS'(op_b);
			first_s1 <= cmd.first;
			last_s1  <= cmd.last;
			cmp_s1   <= cmd.compose;
			col_s1   <= cmd.col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= cmd.issue;
	end

	// stage 2: floor shift and exact accumulation
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			for (int l = 0; l < 4; l++) begin
				if (first_s1)
					acc_s2[l] <= ACC_BITS'(prod_s1[l] >>> FRAC_BITS);
				else
					acc_s2[l] <= acc_s2[l] + ACC_BITS'(prod_s1[l] >>> FRAC_BITS);
			end
			cmp_s2 <= cmp_s1;
			col_s2 <= col_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_s2 <= 1'b0;
		else
			done_s2 <= vld_s1 && last_s1;
	end

	// saturation per lane
	always_comb begin
		for (int l = 0; l < 4; l++)
			sat_r[l] = sat_word(acc_s2[l]);
	end

	// composed column into the next-matrix buffer, vertex into output word
	always_ff @(posedge clk) begin
		if (done_s2 && cmp_s2) begin
			for (int l = 0; l < 4; l++)
				nxt_q[{col_s2, 2'(l)}] <= sat_r[l].val;
		end
		if (done_s2 && !cmp_s2) begin
			for (int l = 0; l < 4; l++)
				out_q[l] <= sat_r[l].val;
			sat_q <= sat_r[0].clip | sat_r[1].clip | sat_r[2].clip | sat_r[3].clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (done_s2 && !cmp_s2)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid    = out_valid_q;
	assign out_x        = out_q[0];
	assign out_y        = out_q[1];
	assign out_z        = out_q[2];
	assign out_w        = out_q[3];
	assign saturated    = sat_q;
	assign sts.out_full = out_valid_q;
	assign sts.res_done = done_s2;

endmodule

`default_nettype wire

// ===== rtl/hte_checker.sv =====
// Port-level checks for the transform engine, bound to the top level.
// Depends on hte_pkg and homogeneous_transform_engine_unit.
`timescale 1ns / 1ps
`default_nettype none

module hte_checker import hte_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [2:0] command,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire word_t      out_x,
	input wire logic       saturated
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// a stalled result keeps out_valid, out_x and saturated
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(saturated))
		else $error("stalled result word changed");

	// a vertex keeps the engine busy past the accepting cycle
	a_xform_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && command == CMD_XFORM |=> !in_ready)
		else $error("ready right after vertex accept");

	// a compose keeps the engine busy past the accepting cycle
	a_compose_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && command == CMD_COMPOSE |=> !in_ready)
		else $error("ready right after compose accept");

	// matrix edits finish at once and never produce a result
	a_edit_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (command == CMD_WRITE || command == CMD_COPY || command == CMD_IDENT)
		|=> in_ready && !$rose(out_valid))
		else $error("matrix edit stalled or produced a result");

endmodule

bind homogeneous_transform_engine_unit hte_checker u_hte_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.command   (command),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_x     (out_x),
	.saturated (saturated)
);

`default_nettype wire
